// File: rtl/page_table_walk_presence_check_unit_defines.svh
// ----------------------------------------------------------------------------
// Page table walk presence check - assertion macros
// Concurrent checks on the block's clock; compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef PAGE_TABLE_WALK_PRESENCE_CHECK_UNIT_DEFINES_SVH
`define PAGE_TABLE_WALK_PRESENCE_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTH
// check that is masked while reset is high
`define PTWPC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("ptwpc check failed");
// check that also holds through reset
`define PTWPC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("ptwpc check failed");
`else
`define PTWPC_ASSERT(label, prop)
`define PTWPC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// File: rtl/ptwpc_pkg.sv
// ----------------------------------------------------------------------------
// ptwpc_pkg
// Shared constants and codes for the page table walk presence check.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwpc_pkg;

   localparam int unsigned LEVELS_DEFAULT = 4;
   localparam int unsigned INDEX_BITS     = 9;
   localparam int unsigned PAGE_SHIFT     = 12;
   localparam int unsigned VA_W           = 48;
   localparam int unsigned ENTRY_W        = 64;
   localparam int unsigned PADDR_W        = 52;
   localparam int unsigned CSR_ADDR_W     = 4;
   localparam int unsigned CSR_DATA_W     = 64;
   localparam int unsigned REQ_DATA_W     = 112;  // va + read data, whole bytes
   localparam int unsigned RSP_DATA_W     = 56;   // address + allocated, padded

   // register index (byte address / 8)
   localparam logic REG_TABLE_ROOT = 1'b0;

   // input item kinds
   localparam logic KIND_LOOKUP    = 1'b0;
   localparam logic KIND_READ_DATA = 1'b1;

   // result item kinds
   localparam logic RESULT_READ_REQ = 1'b0;
   localparam logic RESULT_ANSWER   = 1'b1;

endpackage

`default_nettype wire

// File: rtl/page_table_walk_presence_check_unit.sv
// ----------------------------------------------------------------------------
// page_table_walk_presence_check_unit
// Page table walker (LEVELS levels, four by default) that answers whether a virtual address maps.
// ----------------------------------------------------------------------------
// An input transfer goes to the input register, then its result to the result
//    register; items that cause no result are dropped there.
// Throughput: one item per cycle; a stalled result back-pressures the input.
// Reset (synchronous, active high) clears the walker to idle at level zero,
//    empties both registers and clears table_root to zero.
`default_nettype none

module page_table_walk_presence_check_unit
   import ptwpc_pkg::*;
#(
   parameter int unsigned LEVELS = LEVELS_DEFAULT   // table levels walked, 2..5
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // lookup / read data input
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [47:0] virtual_address, [111:48] read_data
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  wire logic                  req_tuser,

   // read request / answer output
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [51:0] read_address, [52] allocated, [55:53] zero
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   // [0] result_kind
   output logic                       rsp_tuser,

   // configuration: table_root at byte address 0
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   // root table register; only bits 51:12 feed the first read address
   logic [ENTRY_W-1:0] table_root;

   ptwpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .table_root  (table_root)
   );

   // Walker: a lookup while a walk is live, or read data while idle, is
   // consumed with no result. Each read request names the entry at the
   // table base plus index times eight; a zero entry answers not allocated,
   // a nonzero entry at the last level answers allocated.
   ptwpc_core #(
      .LEVELS (LEVELS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .table_root (table_root),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// File: rtl/ptwpc_csr.sv
// ----------------------------------------------------------------------------
// ptwpc_csr
// APB-style register file holding the root table register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptwpc_csr
   import ptwpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic      [ENTRY_W-1:0]    table_root
);

   logic [ENTRY_W-1:0] table_root_ff;
   logic [ENTRY_W-1:0] table_root_in;
   logic               reg_index;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3];   // 8-byte register slots
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      table_root_in = table_root_ff;
      csr_prdata    = '0;
      case (reg_index)
         REG_TABLE_ROOT: begin
            csr_prdata = table_root_ff;
            if (wr_en) begin
               table_root_in = csr_pwdata;
            end
         end
         default: begin
            csr_prdata = '0;   // unmapped slot: reads zero, writes dropped
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_root_ff <= '0;
      end else begin
         table_root_ff <= table_root_in;
      end
   end

   assign table_root = table_root_ff;

endmodule

`default_nettype wire

// File: rtl/ptwpc_core.sv
// ----------------------------------------------------------------------------
// ptwpc_core
// Input register, walk state and result register of the presence check.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_table_walk_presence_check_unit_defines.svh"

module ptwpc_core
   import ptwpc_pkg::*;
#(
   parameter int unsigned LEVELS = LEVELS_DEFAULT
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ENTRY_W-1:0]    table_root,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   output logic                       rsp_tuser
);

   localparam int unsigned LEVEL_W = $clog2(LEVELS);
   localparam int unsigned TOP_SHIFT = PAGE_SHIFT + INDEX_BITS * LEVELS;
   localparam int unsigned EXT_W = (TOP_SHIFT > VA_W) ? TOP_SHIFT : VA_W;
   localparam int unsigned SHIFT_W = $clog2(EXT_W + 1);
   localparam logic [LEVEL_W-1:0] LAST_LEVEL = LEVEL_W'(LEVELS - 1);

   // nine-bit table index of a virtual address at a walk level;
   // index bits above the address read as zero
   function automatic logic [INDEX_BITS-1:0] entry_index(
      input logic [VA_W-1:0]    va,
      input logic [LEVEL_W-1:0] lvl
   );
      logic [EXT_W-1:0]   va_ext;
      logic [SHIFT_W-1:0] shamt;
      va_ext = EXT_W'(va);
      shamt  = SHIFT_W'(PAGE_SHIFT + INDEX_BITS * (LEVELS - 1 - int'(lvl)));
      return INDEX_BITS'(va_ext >> shamt);
   endfunction

   // base bits 51:12 with the index times eight in the low 12 bits; no carry
   function automatic logic [PADDR_W-1:0] entry_addr(
      input logic [ENTRY_W-1:0]    entry,
      input logic [INDEX_BITS-1:0] idx
   );
      return {entry[PADDR_W-1:PAGE_SHIFT], idx, 3'b000};
   endfunction

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic                  in_kind_ff, in_kind_in;
   logic [VA_W-1:0]       in_va_ff, in_va_in;
   logic [ENTRY_W-1:0]    in_data_ff, in_data_in;

   // walk state
   logic                  busy_ff, busy_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [VA_W-1:0]       saved_va_ff, saved_va_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   logic                  out_kind_ff, out_kind_in;
   logic [PADDR_W-1:0]    out_addr_ff, out_addr_in;
   logic                  out_alloc_ff, out_alloc_in;

   logic                  out_free;
   logic                  proc;
   logic                  emit;
   logic                  res_kind;
   logic [PADDR_W-1:0]    res_addr;
   logic                  res_alloc;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_kind_in  = in_kind_ff;
      in_va_in    = in_va_ff;
      in_data_in  = in_data_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_kind_in  = req_tuser;
         in_va_in    = req_tdata[VA_W-1:0];
         in_data_in  = req_tdata[VA_W+ENTRY_W-1:VA_W];
      end
   end

   // one walk step per item
   always_comb begin
      busy_in     = busy_ff;
      level_in    = level_ff;
      saved_va_in = saved_va_ff;
      emit        = 1'b0;
      res_kind    = RESULT_READ_REQ;
      res_addr    = '0;
      res_alloc   = 1'b0;
      if (proc) begin
         case (in_kind_ff)
            KIND_LOOKUP: begin
               if (!busy_ff) begin
                  busy_in     = 1'b1;
                  level_in    = '0;
                  saved_va_in = in_va_ff;
                  emit        = 1'b1;
                  res_addr    = entry_addr(table_root, entry_index(in_va_ff, '0));
               end
            end
            KIND_READ_DATA: begin
               if (busy_ff) begin
                  emit = 1'b1;
                  if (in_data_ff == '0) begin
                     busy_in  = 1'b0;
                     level_in = '0;
                     res_kind = RESULT_ANSWER;
                  end else if (level_ff == LAST_LEVEL) begin
                     busy_in   = 1'b0;
                     level_in  = '0;
                     res_kind  = RESULT_ANSWER;
                     res_alloc = 1'b1;
                  end else begin
                     level_in = level_ff + 1'b1;
                     res_addr = entry_addr(in_data_ff,
                                           entry_index(saved_va_ff, level_ff + 1'b1));
                  end
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_addr_in  = out_addr_ff;
      out_alloc_in = out_alloc_ff;
      if (out_free) begin
         out_valid_in = proc && emit;
         out_kind_in  = res_kind;
         out_addr_in  = res_addr;
         out_alloc_in = res_alloc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         busy_ff      <= 1'b0;
         level_ff     <= '0;
         saved_va_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         busy_ff      <= busy_in;
         level_ff     <= level_in;
         saved_va_ff  <= saved_va_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_kind_ff   <= in_kind_in;
      in_va_ff     <= in_va_in;
      in_data_ff   <= in_data_in;
      out_kind_ff  <= out_kind_in;
      out_addr_ff  <= out_addr_in;
      out_alloc_ff <= out_alloc_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_alloc_ff, out_addr_ff});

   `PTWPC_ASSERT(a_level_in_range, level_ff <= LAST_LEVEL)
   `PTWPC_ASSERT(a_idle_level_zero, !busy_ff |-> level_ff == '0)
   `PTWPC_ASSERT(a_read_req_keeps_busy,
                 (proc && emit && res_kind == RESULT_READ_REQ) |=> busy_ff)
   `PTWPC_ASSERT(a_answer_ends_walk,
                 (proc && emit && res_kind == RESULT_ANSWER) |=> !busy_ff)

endmodule

`default_nettype wire
